// ===== hdl/tcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor package
// Item types, command codes and constants shared by the cursor engine.
// ----------------------------------------------------------------------------
package tcc_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [7:0] RESET_ATTR = 8'h07;
    localparam logic [7:0] CH_NL      = 8'd10;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    typedef enum logic [2:0] {
        CMD_RESET     = 3'd0,
        CMD_PUT       = 3'd1,
        CMD_INSERT    = 3'd2,
        CMD_MOVE      = 3'd3,
        CMD_SET_COLOR = 3'd4,
        CMD_ROW_MOVE  = 3'd5,
        CMD_BACKSPACE = 3'd6
    } t_cmd;

    typedef struct packed {
        logic [2:0]        cmd;
        logic [7:0]        ch;
        logic [7:0]        color;
        logic              use_default;
        logic signed [7:0] arg_x;
        logic [6:0]        arg_y;
    } t_in_item;

    typedef struct packed {
        logic        write_valid;
        logic [10:0] write_addr;
        logic [15:0] write_data;
        logic        clear_screen;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic [7:0]  current_color;
    } t_out_item;

endpackage

// ===== hdl/tcc_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Cursor step logic
// Works out the next cursor state and the result item for one command.
// ----------------------------------------------------------------------------
module tcc_step #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
    input  tcc_pkg::t_in_item          i_item,
    input  logic [$clog2(ROWS+1)-1:0]    i_row,
    input  logic [$clog2(COLUMNS+1)-1:0] i_col,
    input  logic [7:0]                   i_attr,
    output logic [$clog2(ROWS+1)-1:0]    o_row,
    output logic [$clog2(COLUMNS+1)-1:0] o_col,
    output logic [7:0]                   o_attr,
    output tcc_pkg::t_out_item           o_result
);

    localparam int RW = $clog2(ROWS + 1);
    localparam int CW = $clog2(COLUMNS + 1);
    localparam int AW = RW + CW + 1;

    logic signed [7:0] delta;
    logic signed [8:0] col_sum;
    logic [CW-1:0]     col_moved;
    logic [RW-1:0]     row_inc;
    logic [CW-1:0]     col_inc;
    logic [CW-1:0]     addr_col;
    logic [AW-1:0]     addr_full;
    logic [7:0]        put_attr;
    logic              move_bad;
    logic [6:0]        row_ext;
    logic [6:0]        col_ext;
    logic [RW-1:0]     nx_row;
    logic [CW-1:0]     nx_col;
    logic [7:0]        nx_attr;
    logic              wv;
    logic              clr;
    logic [15:0]       data;

    // Shared saturating in-row move; backspace is a move by minus one.
    assign delta   = (tcc_pkg::t_cmd'(i_item.cmd) == tcc_pkg::CMD_BACKSPACE) ?
                     8'sh ff : i_item.arg_x;
    assign col_sum = $signed({{(9-CW){1'b0}}, i_col}) + 9'(delta);

    always_comb begin
        if (col_sum < 9'sd0) begin
            col_moved = '0;
        end else if (col_sum >= 9'(COLUMNS)) begin
            col_moved = CW'(COLUMNS - 1);
        end else begin
            col_moved = col_sum[CW-1:0];
        end
    end

    assign row_inc  = i_row + RW'(1);
    assign col_inc  = i_col + CW'(1);
    assign put_attr = i_item.use_default ? i_attr : i_item.color;
    assign move_bad = i_item.arg_x[7] || ({1'b0, i_item.arg_x[6:0]} >= 8'(COLUMNS)) ||
                      ({1'b0, i_item.arg_y} >= 8'(ROWS));

    // Backspace writes at the column after the move, all others at the cursor.
    assign addr_col  = (tcc_pkg::t_cmd'(i_item.cmd) == tcc_pkg::CMD_BACKSPACE) ?
                       col_moved : i_col;
    assign addr_full = AW'(i_row) * AW'(COLUMNS) + AW'(addr_col);

    always_comb begin
        nx_row  = i_row;
        nx_col  = i_col;
        nx_attr = i_attr;
        wv      = 1'b0;
        clr     = 1'b0;
        data    = '0;
        unique case (tcc_pkg::t_cmd'(i_item.cmd))
            tcc_pkg::CMD_RESET: begin
                nx_row  = '0;
                nx_col  = '0;
                nx_attr = tcc_pkg::RESET_ATTR;
                clr     = 1'b1;
            end
            tcc_pkg::CMD_PUT: begin
                if (i_item.ch == tcc_pkg::CH_NL) begin
                    nx_row = row_inc;
                    nx_col = '0;
                end else if (i_item.ch == tcc_pkg::CH_CR) begin
                    nx_col = '0;
                end else begin
                    wv   = 1'b1;
                    data = {put_attr, i_item.ch};
                    if (col_inc == CW'(COLUMNS)) begin
                        nx_col = '0;
                        nx_row = row_inc;
                    end else begin
                        nx_col = col_inc;
                    end
                end
                // Running off the last row clears the screen; a pending write
                // is still reported with the clear.
                if (nx_row == RW'(ROWS)) begin
                    nx_row  = '0;
                    nx_col  = '0;
                    nx_attr = tcc_pkg::RESET_ATTR;
                    clr     = 1'b1;
                end
            end
            tcc_pkg::CMD_INSERT: begin
                wv   = 1'b1;
                data = {i_attr, i_item.ch};
            end
            tcc_pkg::CMD_MOVE: begin
                if (move_bad) begin
                    nx_row = '0;
                    nx_col = '0;
                end else begin
                    nx_row = i_item.arg_y[RW-1:0];
                    nx_col = i_item.arg_x[CW-1:0];
                end
            end
            tcc_pkg::CMD_SET_COLOR: begin
                nx_attr = i_item.color;
            end
            tcc_pkg::CMD_ROW_MOVE: begin
                nx_col = col_moved;
            end
            tcc_pkg::CMD_BACKSPACE: begin
                nx_col = col_moved;
                wv     = 1'b1;
                data   = {i_attr, tcc_pkg::CH_SPACE};
            end
            default: begin
            end
        endcase
    end

    assign row_ext = 7'(nx_row);
    assign col_ext = 7'(nx_col);

    assign o_row  = nx_row;
    assign o_col  = nx_col;
    assign o_attr = nx_attr;

    always_comb begin
        o_result.write_valid   = wv;
        o_result.write_addr    = wv ? 11'(addr_full) : 11'd0;
        o_result.write_data    = data;
        o_result.clear_screen  = clr;
        o_result.cursor_row    = row_ext[4:0];
        o_result.cursor_col    = col_ext;
        o_result.current_color = nx_attr;
    end

endmodule

// ===== hdl/text_console_cursor_writer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor writer
// Cursor engine: one command per item, one result item with an optional
// cell write and a screen clear flag.
// ----------------------------------------------------------------------------
// Path: an accepted item is held in the input register, then moves into the
// result register, from which it leaves when the output is ready.
// Throughput: one item per cycle while the output is not stalled; the cursor
// state updates as an item moves into the result register.
// Reset: cursor at row 0, column 0, default color 0x07, both stages empty.
module text_console_cursor_writer #(
    parameter int COLUMNS = tcc_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcc_pkg::ROWS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcc_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcc_pkg::t_out_item  o_out_data
);

    localparam int RW = $clog2(ROWS + 1);
    localparam int CW = $clog2(COLUMNS + 1);

    tcc_pkg::t_in_item  r_in;
    logic               r_in_valid;
    tcc_pkg::t_out_item r_out;
    logic               r_out_valid;
    logic [RW-1:0]      r_row;
    logic [CW-1:0]      r_col;
    logic [7:0]         r_attr;

    logic [RW-1:0]      n_row;
    logic [CW-1:0]      n_col;
    logic [7:0]         n_attr;
    tcc_pkg::t_out_item n_out;
    logic               advance;
    logic               take_in;

    tcc_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .i_item   (r_in),
        .i_row    (r_row),
        .i_col    (r_col),
        .i_attr   (r_attr),
        .o_row    (n_row),
        .o_col    (n_col),
        .o_attr   (n_attr),
        .o_result (n_out)
    );

    // An item moves on when the result register is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;
    assign take_in    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_row       <= '0;
            r_col       <= '0;
            r_attr      <= tcc_pkg::RESET_ATTR;
        end else begin
            if (take_in) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_row       <= n_row;
                r_col       <= n_col;
                r_attr      <= n_attr;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_in) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
